FILE: rtl/mkps_pkg.sv
// ----------------------------------------------------------------------------
// mkps_pkg
// Shared constants, types and the key table for the matrix keypad scanner.
// ----------------------------------------------------------------------------
package mkps_pkg;

    // Default geometry
    localparam int NUM_ROWS_DEF = 4;
    localparam int NUM_COLS_DEF = 3;

    // Field widths
    localparam int COLS_W   = 3;
    localparam int TICKS_W  = 16;
    localparam int ROWDRV_W = 4;
    localparam int KEY_W    = 7;
    localparam int HASH_W   = 2;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd1;

    // Reset values of the configuration registers
    localparam logic [TICKS_W-1:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [TICKS_W-1:0] LONG_PRESS_RST = 16'd3000;
    localparam logic [TICKS_W-1:0] TICKS_MAX      = 16'hFFFF;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_HASH = 7'h23;   // '#'

    // Hash hold classes
    localparam logic [HASH_W-1:0] HASH_NONE  = 2'd0;
    localparam logic [HASH_W-1:0] HASH_LONG  = 2'd1;
    localparam logic [HASH_W-1:0] HASH_SHORT = 2'd2;

    // Scanner phases, one-hot
    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,  // rotate row
        PH_DETECT   = 6'b000010,  // look for a press
        PH_PRESS_DB = 6'b000100,  // press debounce
        PH_RELEASE  = 6'b001000,  // wait for release
        PH_REL_DB   = 6'b010000,  // release debounce
        PH_CLASSIFY = 6'b100000   // classify hash hold
    } phase_t;

    // ASCII code of the key at (row, col) of the 4x3 pad; 0 outside it
    function automatic logic [KEY_W-1:0] key_lookup(input logic [2:0] row,
                                                    input logic [1:0] col);
        logic [KEY_W-1:0] code;
        code = '0;
        case ({row, col})
            5'b000_00: code = 7'h31;  // '1'
            5'b000_01: code = 7'h32;  // '2'
            5'b000_10: code = 7'h33;  // '3'
            5'b001_00: code = 7'h34;  // '4'
            5'b001_01: code = 7'h35;  // '5'
            5'b001_10: code = 7'h36;  // '6'
            5'b010_00: code = 7'h37;  // '7'
            5'b010_01: code = 7'h38;  // '8'
            5'b010_10: code = 7'h39;  // '9'
            5'b011_00: code = 7'h2A;  // '*'
            5'b011_01: code = 7'h30;  // '0'
            5'b011_10: code = KEY_HASH;
            default:   code = '0;
        endcase
        return code;
    endfunction

endpackage

FILE: rtl/matrix_keypad_scanner_top.sv
// A result appears on the master side in the cycle after its request is taken.
// Throughput: one request per cycle; the scan state machine and the output
// register both update in the accepting cycle, so a held output only stalls intake.
// Reset (rst_n low, asynchronous): phase idle, row 0, counters and key cleared,
// debounce 20 ticks, long press 3000 ticks, no result pending.
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_top
// 4x3 keypad scanner with press/release debounce and long/short hash detection.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_top
    import mkps_pkg::*;
#(
    parameter int NUM_ROWS = NUM_ROWS_DEF,
    parameter int NUM_COLS = NUM_COLS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICKS_W-1:0]   cfg_data,
    // Request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // [2:0] columns, [3] tick, [7:4] zero
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata    // [3:0] row_drive, [10:4] key_code,
                                            // [11] key_ready, [13:12] hash_hold,
                                            // [15:14] zero
);

    localparam int ROW_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int USED_C = (NUM_COLS >= COLS_W) ? COLS_W : NUM_COLS;
    localparam logic [COLS_W-1:0] COL_MASK = COLS_W'((1 << USED_C) - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(NUM_ROWS - 1);

    // Configuration registers
    logic [TICKS_W-1:0] debounce_reg;
    logic [TICKS_W-1:0] long_press_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RST;
            long_press_reg <= LONG_PRESS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Scan state
    phase_t              phase_reg,      phase_next;
    logic [ROW_W-1:0]    row_index_reg,  row_index_next;
    logic [TICKS_W-1:0]  tick_count_reg, tick_count_next;
    logic [KEY_W-1:0]    latched_key_reg, latched_key_next;
    logic [TICKS_W-1:0]  hold_length_reg, hold_length_next;
    logic                ready_flag_reg, ready_flag_next;
    logic [HASH_W-1:0]   hash_class_reg, hash_class_next;
    logic [ROWDRV_W-1:0] row_drive_reg,  row_drive_next;

    // Output register
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic               accept;
    logic [COLS_W-1:0]  cols;
    logic               tick;
    logic               pressed;
    logic [TICKS_W-1:0] tc_inc;
    logic [1:0]         first_col;
    logic [ROW_W-1:0]   row_adv;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cols     = s_tdata[COLS_W-1:0] & COL_MASK;
    assign tick     = s_tdata[COLS_W];
    assign pressed  = |cols;
    assign tc_inc   = (tick && (tick_count_reg != TICKS_MAX)) ? tick_count_reg + 1'b1
                                                              : tick_count_reg;
    assign row_adv  = (row_index_reg == ROW_LAST) ? '0 : row_index_reg + 1'b1;

    // Lowest pressed column wins
    always_comb
    begin
        first_col = 2'd0;
        if (cols[0])
            first_col = 2'd0;
        else if (cols[1])
            first_col = 2'd1;
        else if (cols[2])
            first_col = 2'd2;
    end

    // Phase logic for one request
    always_comb
    begin
        phase_next       = phase_reg;
        row_index_next   = row_index_reg;
        tick_count_next  = tc_inc;
        latched_key_next = latched_key_reg;
        hold_length_next = hold_length_reg;
        ready_flag_next  = ready_flag_reg;
        hash_class_next  = hash_class_reg;
        row_drive_next   = row_drive_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                row_index_next   = row_adv;
                row_drive_next   = (32'(row_adv) < ROWDRV_W)
                                   ? ROWDRV_W'(1 << row_adv) : '0;
                ready_flag_next  = 1'b0;
                hold_length_next = '0;
                phase_next       = PH_DETECT;
            end
            PH_DETECT:
            begin
                if (pressed)
                begin
                    tick_count_next = '0;
                    phase_next      = PH_PRESS_DB;
                end
                else
                    phase_next = PH_IDLE;
            end
            PH_PRESS_DB:
            begin
                if (tc_inc > debounce_reg)
                begin
                    if (pressed)
                    begin
                        latched_key_next = key_lookup(3'(row_index_reg), first_col);
                        phase_next       = PH_RELEASE;
                    end
                    else
                        phase_next = PH_IDLE;
                end
            end
            PH_RELEASE:
            begin
                if (!pressed)
                begin
                    hold_length_next = tc_inc;
                    tick_count_next  = '0;
                    phase_next = (latched_key_reg == KEY_HASH) ? PH_CLASSIFY : PH_REL_DB;
                end
                else
                    hash_class_next = HASH_NONE;
            end
            PH_REL_DB:
            begin
                if (tc_inc > debounce_reg)
                begin
                    if (!pressed)
                        ready_flag_next = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            PH_CLASSIFY:
            begin
                hash_class_next = (hold_length_reg > long_press_reg) ? HASH_LONG : HASH_SHORT;
                tick_count_next = '0;
                phase_next      = PH_REL_DB;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // State registers update on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            row_index_reg   <= '0;
            tick_count_reg  <= '0;
            latched_key_reg <= '0;
            hold_length_reg <= '0;
            ready_flag_reg  <= 1'b0;
            hash_class_reg  <= HASH_NONE;
            row_drive_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            row_index_reg   <= row_index_next;
            tick_count_reg  <= tick_count_next;
            latched_key_reg <= latched_key_next;
            hold_length_reg <= hold_length_next;
            ready_flag_reg  <= ready_flag_next;
            hash_class_reg  <= hash_class_next;
            row_drive_reg   <= row_drive_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (accept)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            m_tdata_reg <= {2'b00, hash_class_next, ready_flag_next,
                            latched_key_next, row_drive_next};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_ready_only_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready_flag_reg |-> (phase_reg == PH_IDLE))
        else $error("key ready set outside idle phase");

    a_hash_class_source: assert property (@(posedge clk) disable iff (!rst_n)
        (hash_class_reg != HASH_NONE) && ($past(hash_class_reg) == HASH_NONE)
        |-> ($past(phase_reg) == PH_CLASSIFY))
        else $error("hash class set outside classify phase");

    a_key_latch_source: assert property (@(posedge clk) disable iff (!rst_n)
        (latched_key_reg != $past(latched_key_reg)) |-> (phase_reg == PH_RELEASE))
        else $error("key latched without entering release wait");

    a_row_drive_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(row_drive_reg))
        else $error("row drive not one-hot");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid_reg)
        else $error("accepted request produced no result");

endmodule

FILE: test/matrix_keypad_scanner_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_top_test
// Self-checking bench for the keypad scanner. Key strokes on chosen rows with
// bounce, holds of random length and raw column noise are sent through the
// request stream under bursty sending and a patterned result stall. A
// scoreboard with its own scan model predicts every result and compares it
// field by field. The bench sweeps several debounce and long press settings.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_top_test;
    import mkps_pkg::*;

    localparam int STALL_LIMIT = 2000;

    // Result layout, lowest field in the lowest bits
    typedef struct packed {
        logic [HASH_W-1:0]   hash_hold;
        logic                key_ready;
        logic [KEY_W-1:0]    key_code;
        logic [ROWDRV_W-1:0] row_drive;
    } scan_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: scan model plus the queue of pending results
    // ------------------------------------------------------------------------
    class keypad_scoreboard;
        logic [TICKS_W-1:0]  debounce;
        logic [TICKS_W-1:0]  long_press;
        phase_t              phase;
        logic [1:0]          row;
        logic [TICKS_W-1:0]  ticks;
        logic [KEY_W-1:0]    key;
        logic [TICKS_W-1:0]  hold;
        logic                ready;
        logic [HASH_W-1:0]   hash_cls;
        logic [ROWDRV_W-1:0] row_drv;
        string               pad_rows [4];
        scan_result_t        pending_results [$];
        int                  errors;
        int                  requests;
        int                  results;
        int                  keys_latched;
        int                  ready_pulses;
        int                  long_holds;
        int                  short_holds;

        function new();
            pad_rows   = '{"123", "456", "789", "*0#"};
            debounce   = DEBOUNCE_RST;
            long_press = LONG_PRESS_RST;
            phase      = PH_IDLE;
            row        = '0;
            ticks      = '0;
            key        = '0;
            hold       = '0;
            ready      = 1'b0;
            hash_cls   = HASH_NONE;
            row_drv    = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICKS_W-1:0] value);
            if (idx == REG_DEBOUNCE)
                debounce = value;
            else
                long_press = value;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Advance the scan model by one request and queue its result
        function void note_request(logic [COLS_W-1:0] cols, logic tick);
            logic         pressed;
            int           col;
            scan_result_t res;
            pressed = (cols != '0);
            col     = cols[0] ? 0 : (cols[1] ? 1 : 2);
            if (tick && ticks != TICKS_MAX)
                ticks++;
            case (phase)
                PH_IDLE:
                begin
                    row     = row + 2'd1;
                    row_drv = 4'b0001 << row;
                    ready   = 1'b0;
                    hold    = '0;
                    phase   = PH_DETECT;
                end
                PH_DETECT:
                begin
                    if (pressed)
                    begin
                        ticks = '0;
                        phase = PH_PRESS_DB;
                    end
                    else
                        phase = PH_IDLE;
                end
                PH_PRESS_DB:
                begin
                    if (ticks > debounce)
                    begin
                        if (pressed)
                        begin
                            key   = 7'(pad_rows[row][col]);
                            phase = PH_RELEASE;
                            keys_latched++;
                        end
                        else
                            phase = PH_IDLE;
                    end
                end
                PH_RELEASE:
                begin
                    if (!pressed)
                    begin
                        hold  = ticks;
                        ticks = '0;
                        phase = (key == KEY_HASH) ? PH_CLASSIFY : PH_REL_DB;
                    end
                    else
                        hash_cls = HASH_NONE;
                end
                PH_REL_DB:
                begin
                    if (ticks > debounce)
                    begin
                        if (!pressed)
                        begin
                            ready = 1'b1;
                            ready_pulses++;
                        end
                        phase = PH_IDLE;
                    end
                end
                PH_CLASSIFY:
                begin
                    if (hold > long_press)
                    begin
                        hash_cls = HASH_LONG;
                        long_holds++;
                    end
                    else
                    begin
                        hash_cls = HASH_SHORT;
                        short_holds++;
                    end
                    ticks = '0;
                    phase = PH_REL_DB;
                end
                default:
                    phase = PH_IDLE;
            endcase
            res.row_drive = row_drv;
            res.key_code  = key;
            res.key_ready = ready;
            res.hash_hold = hash_cls;
            pending_results.push_back(res);
            requests++;
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result with the oldest pending one
        function void check_result(logic [M_DATA_W-1:0] data);
            scan_result_t want;
            scan_result_t got;
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result %h with nothing pending", $time, data);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            got  = data[$bits(scan_result_t)-1:0];
            results++;
            compare_field("row_drive", 16'(want.row_drive), 16'(got.row_drive));
            compare_field("key_code", 16'(want.key_code), 16'(got.key_code));
            compare_field("key_ready", 16'(want.key_ready), 16'(got.key_ready));
            compare_field("hash_hold", 16'(want.hash_hold), 16'(got.hash_hold));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TICKS_W-1:0]   cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;   // [2:0] columns, [3] tick, [7:4] zero
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;   // [3:0] row_drive, [10:4] key_code,
                                     // [11] key_ready, [13:12] hash_hold

    keypad_scoreboard sb;
    int               sent_count;
    int               burst_left;
    int               settings_count;
    int               stall_cycles = 0;
    int               rx_mode = 0;
    int               rx_left = 0;
    int               rx_cyc = 0;

    matrix_keypad_scanner_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side stall pattern: the mode is redrawn at random intervals
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(50, 300);
        end
        rx_left--;
        rx_cyc++;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ((rx_cyc % 5) != 0);
            default: m_tready <= ((rx_cyc % 32) >= 20);
        endcase
    end

    // Result monitor and progress counter
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // Watchdog
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t watchdog: no request or result moved for %0d cycles",
                 $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------
    function automatic logic tick_draw(input int pct);
        return ($urandom_range(0, 99) < pct);
    endfunction

    // One request; bursts of random length with random gaps between them
    task automatic send_item(input logic [COLS_W-1:0] cols, input logic tick);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, tick, cols};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(cols, tick);
        sent_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICKS_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // Drain all results, let the pipe settle, then load both registers
    task automatic apply_setting(input logic [TICKS_W-1:0] db, input logic [TICKS_W-1:0] lp);
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        write_reg(REG_DEBOUNCE, db);
        write_reg(REG_LONG_PRESS, lp);
        settings_count++;
    endtask

    task automatic run_noise(input int count);
        repeat (count) send_item(3'($urandom_range(0, 7)), tick_draw(50));
    endtask

    // Press a key on the given row, hold it, release it, with contact bounce
    task automatic key_stroke(input int row, input logic [COLS_W-1:0] cols,
                              input int hold, input int pct);
        int                guard;
        logic [COLS_W-1:0] c;
        // let earlier activity run out back into scanning
        guard = 0;
        while (sb.phase != PH_IDLE && sb.phase != PH_DETECT && guard < 80)
        begin
            send_item(3'b000, tick_draw(pct));
            guard++;
        end
        // rotate to the wanted row; columns are ignored during the rotate step
        guard = 0;
        while (!(sb.phase == PH_DETECT && sb.row == row) && guard < 16)
        begin
            c = (sb.phase == PH_IDLE) ? 3'($urandom_range(0, 7)) : 3'b000;
            send_item(c, tick_draw(pct));
            guard++;
        end
        // press, bouncing now and then inside the debounce window
        guard = 0;
        while (sb.phase != PH_RELEASE && guard < 80)
        begin
            c = cols;
            if (sb.phase == PH_PRESS_DB && $urandom_range(0, 9) == 0)
                c = 3'($urandom_range(0, 7));
            send_item(c, tick_draw(pct));
            guard++;
        end
        // hold; other columns may join in
        repeat (hold)
        begin
            c = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 7)) : cols;
            send_item(c, tick_draw(pct));
        end
        // release until the scan returns to rotating
        guard = 0;
        do
        begin
            c = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : 3'b000;
            send_item(c, tick_draw(pct));
            guard++;
        end
        while (sb.phase != PH_IDLE && guard < 80);
    endtask

    // Random strokes, hash key favored, with stretches of raw noise
    task automatic run_strokes(input int quota);
        int                start;
        int                row;
        logic [COLS_W-1:0] cols;
        start = sent_count;
        while (sent_count - start < quota)
        begin
            if ($urandom_range(0, 9) == 0)
                run_noise($urandom_range(3, 12));
            else
            begin
                row  = $urandom_range(0, 3);
                cols = 3'($urandom_range(1, 7));
                if ($urandom_range(0, 2) == 0)
                begin
                    row  = 3;
                    cols = 3'b100;
                end
                key_stroke(row, cols, $urandom_range(0, 12),
                           ($urandom_range(0, 3) == 0) ? 40 : 100);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        sent_count     = 0;
        burst_left     = 0;
        settings_count = 0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: debounce 20, long press 3000
        run_strokes(60);

        // directed strokes with no debounce and a zero long press threshold
        apply_setting(16'd0, 16'd0);
        key_stroke(3, 3'b100, 2, 100);   // hash held past the threshold
        key_stroke(3, 3'b110, 0, 100);   // column 1 wins over column 2
        key_stroke(0, 3'b111, 0, 100);   // all columns, column 0 wins
        run_strokes(60);

        apply_setting(16'd1, 16'd3);
        run_strokes(100);
        apply_setting(16'd2, 16'd6);
        run_strokes(100);
        apply_setting(16'd0, TICKS_MAX);
        run_strokes(100);
        // press debounce can never finish here
        apply_setting(TICKS_MAX, 16'd2);
        run_noise(30);
        apply_setting(16'd3, 16'd10);
        run_strokes(100);
        apply_setting(16'd1, 16'd4);
        run_strokes(100);
        apply_setting(DEBOUNCE_RST, LONG_PRESS_RST);
        run_strokes(40);

        // drain and let the output register settle
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d requests and checked %0d results over %0d register settings.",
                 sb.requests, sb.results, settings_count);
        $display("Keys latched %0d, ready pulses %0d, hash holds long %0d short %0d.",
                 sb.keys_latched, sb.ready_pulses, sb.long_holds, sb.short_holds);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
